[rtl/cft_pkg.sv]
package cft_pkg;

  // Default sizes of the table and its entries.
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned KeyBitsDef    = 32;
  localparam int unsigned PortBitsDef   = 4;

  // Fixed widths of the item fields.
  localparam int unsigned OpcodeW     = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned EntryCountW = 7;

  // Operation codes carried by an input item. Code three is unused.
  typedef enum logic [OpcodeW-1:0] {
    OP_INSERT      = 2'd0,
    OP_REMOVE_KEY  = 2'd1,
    OP_REMOVE_PORT = 2'd2
  } opcode_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STAT_DONE = 2'd0,
    STAT_DUP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_NONE = 2'd3
  } status_e;

endpackage

[rtl/cft_req_if.sv]
interface cft_req_if #(
  parameter int unsigned KEY_BITS  = cft_pkg::KeyBitsDef,
  parameter int unsigned PORT_BITS = cft_pkg::PortBitsDef
);
  import cft_pkg::*;

  logic                 valid;
  logic                 ready;
  opcode_e              opcode;
  logic [KEY_BITS-1:0]  node_key;
  logic [PORT_BITS-1:0] port;

  modport source (output valid, opcode, node_key, port, input ready);
  modport sink   (input valid, opcode, node_key, port, output ready);

endinterface

[rtl/cft_rsp_if.sv]
interface cft_rsp_if;
  import cft_pkg::*;

  logic                   valid;
  logic                   ready;
  status_e                status;
  logic [EntryCountW-1:0] entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink   (input valid, status, entry_count, output ready);

endinterface

[rtl/compacting_forwarding_table_core.sv]
// Key to port forwarding table with in-place compaction.
// Requests arrive on req_i (valid/ready): opcode, node_key and port. Each
// accepted item yields exactly one item on rsp_o: a status and the number of
// entries held after the operation. Entries are kept dense in insertion order.
// Insert appends unless the key is present or the table is full; remove by key
// deletes the first match; remove by port deletes every match, shifting the
// survivors down.
// One item is handled at a time. The sequencer walks the N stored entries
// through the single read port of the table memory, one entry per cycle;
// an insert that finds its key stops early, and the unused opcode three
// answers without a walk. No new item is taken until the result has moved
// into the output register.
// A result waits in the output register while the receiver stalls, and the
// next item is already accepted meanwhile; a second result then waits inside
// the block until the first is taken.
// Reset empties the table at once by clearing the entry count; the table
// memory needs no clearing pass.
module compacting_forwarding_table_core #(
  parameter int unsigned TABLE_DEPTH = cft_pkg::TableDepthDef,
  parameter int unsigned KEY_BITS    = cft_pkg::KeyBitsDef,
  parameter int unsigned PORT_BITS   = cft_pkg::PortBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cft_req_if.sink   req_i,
  cft_rsp_if.source rsp_o
);
  import cft_pkg::*;

  localparam int unsigned AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned CW      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRY_W = KEY_BITS + PORT_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e               state_q, state_d;
  opcode_e              op_q, op_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [PORT_BITS-1:0] port_q, port_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rd_q, rd_d;
  logic [CW-1:0]        wr_q, wr_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic                 hit_q, hit_d;
  status_e              res_status_q, res_status_d;
  logic [CW-1:0]        res_count_q, res_count_d;
  logic                 rsp_valid_q, rsp_valid_d;
  status_e              rsp_status_q, rsp_status_d;
  logic [EntryCountW-1:0] rsp_count_q, rsp_count_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;

  logic [KEY_BITS-1:0]  rd_key;
  logic [PORT_BITS-1:0] rd_port;
  logic                 key_hit;
  logic                 port_hit;
  logic                 rm_match;
  logic                 keep;
  logic                 last;

  cft_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The shared compare unit looks at the entry read in the previous cycle.
  assign rd_key   = mem_rdata[ENTRY_W-1 -: KEY_BITS];
  assign rd_port  = mem_rdata[PORT_BITS-1:0];
  assign key_hit  = cmp_vld_q && (rd_key == key_q);
  assign port_hit = cmp_vld_q && (rd_port == port_q);
  assign rm_match = (op_q == OP_REMOVE_PORT) ? port_hit : (key_hit && !hit_q);
  assign keep     = cmp_vld_q && !rm_match;
  assign last     = (rd_q == count_q);

  // Sequencer: walk the entries and compare; removes write the survivors back down, inserts append.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    port_d       = port_q;
    count_d      = count_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    cmp_vld_d    = 1'b0;
    hit_d        = hit_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    mem_we       = 1'b0;
    mem_waddr    = wr_q[AW-1:0];
    mem_wdata    = mem_rdata;
    mem_raddr    = rd_q[AW-1:0];

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d   = req_i.opcode;
          key_d  = req_i.node_key;
          port_d = req_i.port;
          rd_d   = '0;
          wr_d   = '0;
          hit_d  = 1'b0;
          if (req_i.opcode == OP_INSERT || req_i.opcode == OP_REMOVE_KEY ||
              req_i.opcode == OP_REMOVE_PORT) begin
            state_d = S_SCAN;
          end else begin
            res_status_d = STAT_NONE;
            res_count_d  = count_q;
            state_d      = S_RESULT;
          end
        end
      end

      S_SCAN: begin
        if (!last) begin
          cmp_vld_d = 1'b1;
          rd_d      = rd_q + 1'b1;
        end
        if (op_q == OP_INSERT) begin
          if (key_hit) begin
            res_status_d = STAT_DUP;
            res_count_d  = count_q;
            state_d      = S_RESULT;
          end else if (last) begin
            if (count_q == CW'(TABLE_DEPTH)) begin
              res_status_d = STAT_FULL;
              res_count_d  = count_q;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = count_q[AW-1:0];
              mem_wdata    = {key_q, port_q};
              count_d      = count_q + 1'b1;
              res_status_d = STAT_DONE;
              res_count_d  = count_q + 1'b1;
            end
            state_d = S_RESULT;
          end
        end else begin
          if (rm_match) begin
            hit_d = 1'b1;
          end
          if (keep) begin
            mem_we = 1'b1;
            wr_d   = wr_q + 1'b1;
          end
          if (last) begin
            count_d      = wr_d;
            res_count_d  = wr_d;
            res_status_d = hit_d ? STAT_DONE : STAT_NONE;
            state_d      = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_count_d  = EntryCountW'(res_count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_INSERT;
      key_q        <= '0;
      port_q       <= '0;
      count_q      <= '0;
      rd_q         <= '0;
      wr_q         <= '0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      res_status_q <= STAT_DONE;
      res_count_q  <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= STAT_DONE;
      rsp_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      key_q        <= key_d;
      port_q       <= port_d;
      count_q      <= count_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      cmp_vld_q    <= cmp_vld_d;
      hit_q        <= hit_d;
      res_status_q <= res_status_d;
      res_count_q  <= res_count_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_status_q <= rsp_status_d;
      rsp_count_q  <= rsp_count_d;
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;

endmodule

[rtl/cft_mem.sv]
module cft_mem #(
  parameter int unsigned DEPTH = cft_pkg::TableDepthDef,
  parameter int unsigned WIDTH = cft_pkg::KeyBitsDef + cft_pkg::PortBitsDef,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import cft_pkg::*;

  localparam int unsigned TABLE_DEPTH  = TableDepthDef;
  localparam int unsigned KEY_BITS     = KeyBitsDef;
  localparam int unsigned PORT_BITS    = PortBitsDef;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned IDLE_PCT     = 7;
  localparam int unsigned POOL_SIZE    = 96;
  localparam int unsigned HOLD_AFTER   = 200;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_AT     = 1200;

  // The opcode left unused by the package.
  localparam opcode_e OP_UNUSED = opcode_e'(2'd3);

  typedef struct {
    opcode_e                op;
    logic [KEY_BITS-1:0]    key;
    logic [PORT_BITS-1:0]   prt;
    bit                     typed;
    status_e                st;
    logic [EntryCountW-1:0] cnt;
  } stim_row_t;

  typedef struct {
    status_e                status;
    logic [EntryCountW-1:0] entry_count;
  } table_result_t;

  logic clk_i;
  logic rst_ni;

  cft_req_if #(.KEY_BITS(KEY_BITS), .PORT_BITS(PORT_BITS)) req_if ();
  cft_rsp_if rsp_if ();

  compacting_forwarding_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .PORT_BITS  (PORT_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the table contents.
  logic [KEY_BITS-1:0]  shadow_keys  [TABLE_DEPTH];
  logic [PORT_BITS-1:0] shadow_ports [TABLE_DEPTH];
  int unsigned          shadow_count;

  table_result_t pending_results [$];
  int unsigned   mismatches;
  int unsigned   results_seen;
  int unsigned   cycle_count;
  bit            calm;

  // Directed items: empty table, extreme keys and ports, every opcode and
  // every status but full. Rows with a typed result are not taken from the shadow table.
  stim_row_t directed_rows [19] = '{
    '{OP_REMOVE_KEY,  32'h0000_0000, 4'h0, 1'b1, STAT_NONE, 7'd0},
    '{OP_REMOVE_PORT, 32'h0000_0000, 4'h0, 1'b1, STAT_NONE, 7'd0},
    '{OP_UNUSED,      32'h0000_0000, 4'h0, 1'b1, STAT_NONE, 7'd0},
    '{OP_INSERT,      32'h0000_0000, 4'h0, 1'b1, STAT_DONE, 7'd1},
    '{OP_INSERT,      32'hFFFF_FFFF, 4'hF, 1'b1, STAT_DONE, 7'd2},
    '{OP_INSERT,      32'h0000_0000, 4'h5, 1'b1, STAT_DUP,  7'd2},
    '{OP_INSERT,      32'hFFFF_FFFF, 4'h0, 1'b1, STAT_DUP,  7'd2},
    '{OP_INSERT,      32'h1234_5678, 4'hF, 1'b0, STAT_DONE, 7'd0},
    '{OP_INSERT,      32'hA5A5_A5A5, 4'h3, 1'b0, STAT_DONE, 7'd0},
    '{OP_INSERT,      32'h5A5A_5A5A, 4'hF, 1'b0, STAT_DONE, 7'd0},
    '{OP_REMOVE_PORT, 32'h0000_0000, 4'hF, 1'b0, STAT_DONE, 7'd0},
    '{OP_REMOVE_KEY,  32'hDEAD_BEEF, 4'h0, 1'b1, STAT_NONE, 7'd2},
    '{OP_REMOVE_PORT, 32'h0000_0000, 4'h9, 1'b1, STAT_NONE, 7'd2},
    '{OP_UNUSED,      32'hFFFF_FFFF, 4'hF, 1'b1, STAT_NONE, 7'd2},
    '{OP_INSERT,      32'h1234_5678, 4'hA, 1'b0, STAT_DONE, 7'd0},
    '{OP_REMOVE_KEY,  32'h0000_0000, 4'h0, 1'b0, STAT_DONE, 7'd0},
    '{OP_REMOVE_KEY,  32'hA5A5_A5A5, 4'h0, 1'b0, STAT_DONE, 7'd0},
    '{OP_REMOVE_KEY,  32'h1234_5678, 4'h0, 1'b0, STAT_DONE, 7'd0},
    '{OP_REMOVE_KEY,  32'h1234_5678, 4'h0, 1'b1, STAT_NONE, 7'd0}
  };

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Apply one operation to the shadow table and return its status.
  function automatic status_e update_shadow_table(opcode_e op, logic [KEY_BITS-1:0] key,
                                                  logic [PORT_BITS-1:0] prt);
    int unsigned rd;
    int unsigned wr;
    bit          hit;
    bit          match;
    case (op)
      OP_INSERT: begin
        for (rd = 0; rd < shadow_count; rd++) begin
          if (shadow_keys[rd] == key) return STAT_DUP;
        end
        if (shadow_count >= TABLE_DEPTH) return STAT_FULL;
        shadow_keys[shadow_count]  = key;
        shadow_ports[shadow_count] = prt;
        shadow_count++;
        return STAT_DONE;
      end
      OP_REMOVE_KEY, OP_REMOVE_PORT: begin
        hit = 1'b0;
        wr  = 0;
        // Survivors keep their order; remove by key drops only the first match.
        for (rd = 0; rd < shadow_count; rd++) begin
          match = (op == OP_REMOVE_PORT) ? (shadow_ports[rd] == prt) : (shadow_keys[rd] == key);
          if (match && (op == OP_REMOVE_PORT || !hit)) begin
            hit = 1'b1;
          end else begin
            shadow_keys[wr]  = shadow_keys[rd];
            shadow_ports[wr] = shadow_ports[rd];
            wr++;
          end
        end
        shadow_count = wr;
        return hit ? STAT_DONE : STAT_NONE;
      end
      default: return STAT_NONE;
    endcase
  endfunction

  // Offer one item, wait for it to be taken and queue its expected result.
  task automatic offer_item(opcode_e op, logic [KEY_BITS-1:0] key, logic [PORT_BITS-1:0] prt,
                            bit typed, status_e typed_st, logic [EntryCountW-1:0] typed_cnt);
    table_result_t res;
    status_e       st;
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.node_key <= key;
    req_if.port     <= prt;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    st = update_shadow_table(op, key, prt);
    res.status      = typed ? typed_st : st;
    res.entry_count = typed ? typed_cnt : EntryCountW'(shadow_count);
    pending_results.push_back(res);
  endtask

  // Request side: reset, directed items, random items, then drain.
  initial begin
    logic [KEY_BITS-1:0]  key_pool [POOL_SIZE];
    logic [KEY_BITS-1:0]  key;
    logic [PORT_BITS-1:0] prt;
    opcode_e              op;
    int unsigned          n;
    int unsigned          k;
    int unsigned          roll;
    int unsigned          episode_left;
    int unsigned          episodes;
    int unsigned          insert_pct;

    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.opcode   <= OP_INSERT;
    req_if.node_key <= '0;
    req_if.port     <= '0;
    shadow_count = 0;
    mismatches   = 0;
    calm         = 1'b0;
    episodes     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].prt,
                 directed_rows[i].typed, directed_rows[i].st, directed_rows[i].cnt);
    end

    // Random part in episodes that lean toward filling or emptying the table.
    // The first episode fills it so that full and duplicate cases come early.
    episode_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (episode_left == 0) begin
        if (episodes % 4 == 0) begin
          for (k = 0; k < POOL_SIZE; k++) key_pool[k] = KEY_BITS'($urandom);
        end
        if (episodes == 0) begin
          episode_left = 120;
          insert_pct   = 85;
        end else begin
          episode_left = $urandom_range(40, 120);
          case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 25;
          endcase
        end
        episodes++;
      end
      episode_left--;
      calm = (n >= 500 && n < 800);

      // Let the block run dry once before carrying on.
      if (n == DRAIN_AT) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
        while (pending_results.size() != 0) @(posedge clk_i);
      end

      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 99) < 5) key = KEY_BITS'($urandom);
      prt  = PORT_BITS'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OP_UNUSED;
      end else if (roll < 3 + insert_pct * 97 / 100) begin
        op = OP_INSERT;
      end else if ($urandom_range(0, 2) == 0) begin
        op = OP_REMOVE_PORT;
      end else begin
        op = OP_REMOVE_KEY;
      end
      offer_item(op, key, prt, 1'b0, STAT_DONE, '0);
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("compacting_forwarding_table_core verification clean");
    end else begin
      $display("compacting_forwarding_table_core verification failed");
    end
    $finish;
  end

  // Response side: check each taken item and drive ready, with one long hold-off.
  initial begin
    table_result_t exp_res;
    int unsigned   hold_left;
    bit            hold_done;
    bit            next_ready;

    rsp_if.ready <= 1'b0;
    results_seen = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result item: status %0d entry_count %0d",
                   $time, rsp_if.status, rsp_if.entry_count);
          mismatches++;
        end else begin
          exp_res = pending_results.pop_front();
          if (rsp_if.status !== exp_res.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, exp_res.status, rsp_if.status);
            mismatches++;
          end
          if (rsp_if.entry_count !== exp_res.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d actual %0d",
                     $time, exp_res.entry_count, rsp_if.entry_count);
            mismatches++;
          end
        end
      end

      if (!hold_done && results_seen == HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (calm) begin
        next_ready = 1'b1;
      end else begin
        next_ready = ($urandom_range(0, 99) >= IDLE_PCT);
      end
      rsp_if.ready <= next_ready;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("compacting_forwarding_table_core verification failed");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
